@@ hdl/lcfs_pkg.sv @@
package lcfs_pkg;

	// Default sizes of the position mask and the first-field buffer.
	localparam int unsigned MASK_POSITIONS_DEF = 64;
	localparam int unsigned BUFFER_BYTES_DEF   = 32;

	// Byte codes with a fixed meaning.
	localparam logic [7:0] NL_BYTE  = 8'd10;
	localparam logic [7:0] TAB_BYTE = 8'd9;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS = 3'd5;

	localparam int unsigned CFG_DATA_W = 64;

	// Reset values of the configuration registers.
	localparam logic [6:0] MAX_POS_RST = 7'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_TAIL
	} lcfs_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;      // input beat taken this cycle
		logic load_flush;  // move the current buffer byte into the output register
		logic load_tail;   // move the pending closing byte into the output register
	} lcfs_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;    // output register empty or being emptied
		logic do_flush;    // the offered byte starts a buffer flush
		logic flush_last;  // the buffer byte on hand is the final one
		logic tail_pend;   // a closing byte follows the flush
	} lcfs_status_t;

endpackage

@@ hdl/line_column_field_selector.sv @@
// Channel   Direction  Handshake              Beat carries
// in        into       in_valid / in_ready    in_byte
// out       out of     out_valid / out_ready  out_byte, run_last, truncated
// cfg       into       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte that gives at most one result does not hold the input, so such
// bytes stream at one beat per cycle while the output side keeps up.
// A byte that releases the first-field buffer holds the input while the
// buffered bytes go out one by one through the single read port of the
// buffer memory, followed by any closing delimiter or newline.
// Reset is asynchronous and active low; it restores the register defaults
// and clears the line state. The buffer memory is not cleared.
// A stall on the output holds the input as well, since the output register
// is the only store between the two sides.
module line_column_field_selector #(
	parameter int unsigned MASK_POSITIONS = lcfs_pkg::MASK_POSITIONS_DEF,
	parameter int unsigned BUFFER_BYTES   = lcfs_pkg::BUFFER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      in_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_byte,
	output logic                            run_last,
	output logic                            truncated,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lcfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcfs_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Command and status between the sequencer and the datapath.
	lcfs_pkg::lcfs_cmd_t    cmd;
	lcfs_pkg::lcfs_status_t sts;

	// Register writes are always taken; the user is to issue them only while idle,
	// so no line is in flight when a setting changes. The block does not enforce it.
	assign cfg_ready = 1'b1;

	// The sequencer takes a byte in its idle state, walks the buffer during a
	// release, and then hands over the closing byte if there is one.
	lcfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the settings, the line state, the buffer memory and
	// the output register, and classifies each offered byte.
	lcfs_datapath #(
		.MASK_POSITIONS (MASK_POSITIONS),
		.BUFFER_BYTES   (BUFFER_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_byte),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.truncated (truncated),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

@@ hdl/lcfs_ctrl.sv @@
module lcfs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lcfs_pkg::lcfs_status_t sts,
	output lcfs_pkg::lcfs_cmd_t    cmd
);

	lcfs_pkg::lcfs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd.accept     = 1'b0;
		cmd.load_flush = 1'b0;
		cmd.load_tail  = 1'b0;
		case (state_q)
			lcfs_pkg::ST_IDLE: begin
				in_ready   = sts.out_free;
				cmd.accept = in_valid && sts.out_free;
				if (cmd.accept && sts.do_flush) begin
					state_d = lcfs_pkg::ST_FLUSH;
				end
			end
			lcfs_pkg::ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.load_flush = 1'b1;
					if (sts.flush_last) begin
						state_d = sts.tail_pend ? lcfs_pkg::ST_TAIL : lcfs_pkg::ST_IDLE;
					end
				end
			end
			lcfs_pkg::ST_TAIL: begin
				if (sts.out_free) begin
					cmd.load_tail = 1'b1;
					state_d       = lcfs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lcfs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/lcfs_datapath.sv @@
module lcfs_datapath #(
	parameter int unsigned MASK_POSITIONS = lcfs_pkg::MASK_POSITIONS_DEF,
	parameter int unsigned BUFFER_BYTES   = lcfs_pkg::BUFFER_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [7:0]                         in_byte,
	input  logic                               cfg_valid,
	input  logic [lcfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lcfs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [7:0]                         out_byte,
	output logic                               run_last,
	output logic                               truncated,
	input  lcfs_pkg::lcfs_cmd_t                cmd,
	output lcfs_pkg::lcfs_status_t             sts
);

	localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);
	localparam int unsigned AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam logic [FW-1:0] BUF_FULL = FW'(BUFFER_BYTES);
	localparam logic [7:0]    MPOS     = 8'(MASK_POSITIONS);

	// Configuration registers.
	logic        mode_q;
	logic [63:0] mask_q;
	logic [6:0]  max_pos_q;
	logic        open_q;
	logic [7:0]  delim_q;
	logic        suppress_q;

	// Line state.
	logic [6:0]    count_q;
	logic          dseen_q;
	logic          any_q;
	logic [FW-1:0] fill_q;
	logic          ovf_q;

	// Flush bookkeeping.
	logic [FW-1:0] len_q;
	logic [FW-1:0] idx_q;
	logic          tail_q;
	logic [7:0]    tail_byte_q;
	logic          trunc_q;

	// Buffer memory with registered read.
	logic [7:0]    mem [BUFFER_BYTES];
	logic [7:0]    rd_data_q;

	// Output register.
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          run_last_q;
	logic          truncated_q;

	// Decision for the offered byte.
	logic          res_v;
	logic [7:0]    res_b;
	logic          res_t;
	logic          flush_req;
	logic          wr_en;
	logic [6:0]    n_count;
	logic          n_dseen;
	logic          n_any;
	logic [FW-1:0] n_fill;
	logic          n_ovf;
	logic [6:0]    bumped;
	logic [7:0]    m_eff;
	logic          sel1;
	logic          sel2;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          out_free;
	logic          load_imm;

	function automatic logic pos_sel(
		input logic [7:0]  k,
		input logic [7:0]  m,
		input logic [63:0] mask,
		input logic        open
	);
		logic [7:0] km1;
		km1 = k - 8'd1;
		if (k == 8'd0 || k > m) begin
			return open;
		end
		return mask[km1[5:0]];
	endfunction

	assign m_eff  = ({1'b0, max_pos_q} > MPOS) ? MPOS : {1'b0, max_pos_q};
	assign bumped = (count_q == 7'd127) ? 7'd127 : count_q + 7'd1;
	assign sel1   = pos_sel(8'd1, m_eff, mask_q, open_q);
	assign sel2   = pos_sel(8'd2, m_eff, mask_q, open_q);

	always_comb begin
		res_v     = 1'b0;
		res_b     = in_byte;
		res_t     = ovf_q;
		flush_req = 1'b0;
		wr_en     = 1'b0;
		n_count   = count_q;
		n_dseen   = dseen_q;
		n_any     = any_q;
		n_fill    = fill_q;
		n_ovf     = ovf_q;
		if (!mode_q) begin
			res_t = 1'b0;
			if (in_byte == lcfs_pkg::NL_BYTE) begin
				res_v   = 1'b1;
				n_count = '0;
				n_dseen = 1'b0;
				n_any   = 1'b0;
				n_fill  = '0;
				n_ovf   = 1'b0;
			end else begin
				n_count = bumped;
				res_v   = pos_sel({1'b0, bumped}, m_eff, mask_q, open_q);
			end
		end else if (in_byte == lcfs_pkg::NL_BYTE) begin
			if (dseen_q) begin
				res_v = 1'b1;
			end else if (!suppress_q) begin
				flush_req = 1'b1;
				res_v     = 1'b1;
			end
			n_count = '0;
			n_dseen = 1'b0;
			n_any   = 1'b0;
			n_fill  = '0;
			n_ovf   = 1'b0;
		end else if (!dseen_q) begin
			if (in_byte == delim_q) begin
				n_dseen   = 1'b1;
				flush_req = sel1;
				n_fill    = '0;
				n_count   = 7'd1;
				res_v     = sel2 && (any_q || sel1);
				n_any     = any_q || sel1 || sel2;
			end else if (fill_q < BUF_FULL) begin
				wr_en  = 1'b1;
				n_fill = fill_q + FW'(1);
			end else begin
				n_ovf = 1'b1;
			end
		end else if (in_byte == delim_q) begin
			n_count = bumped;
			if (pos_sel({1'b0, bumped} + 8'd1, m_eff, mask_q, open_q)) begin
				res_v = any_q;
				n_any = 1'b1;
			end
		end else begin
			res_v = pos_sel({1'b0, count_q} + 8'd1, m_eff, mask_q, open_q);
		end
	end

	assign out_free = !out_valid_q || out_ready;

	assign sts.out_free   = out_free;
	assign sts.do_flush   = flush_req && (fill_q != '0);
	assign sts.flush_last = (idx_q == len_q - FW'(1));
	assign sts.tail_pend  = tail_q;

	assign load_imm = cmd.accept && !sts.do_flush && res_v;

	// Byte 0 is fetched as the flush starts; each byte handed on fetches the next.
	assign rd_en   = (cmd.accept && sts.do_flush) || (cmd.load_flush && !sts.flush_last);
	assign rd_addr = cmd.accept ? '0 : AW'(idx_q + FW'(1));

	always_ff @(posedge clk) begin
		if (cmd.accept && wr_en) begin
			mem[fill_q[AW-1:0]] <= in_byte;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			mask_q     <= '0;
			max_pos_q  <= lcfs_pkg::MAX_POS_RST;
			open_q     <= 1'b0;
			delim_q    <= lcfs_pkg::TAB_BYTE;
			suppress_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lcfs_pkg::CFG_MODE:     mode_q     <= cfg_data[0];
				lcfs_pkg::CFG_MASK:     mask_q     <= cfg_data[63:0];
				lcfs_pkg::CFG_MAX_POS:  max_pos_q  <= cfg_data[6:0];
				lcfs_pkg::CFG_OPEN:     open_q     <= cfg_data[0];
				lcfs_pkg::CFG_DELIM:    delim_q    <= cfg_data[7:0];
				lcfs_pkg::CFG_SUPPRESS: suppress_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dseen_q     <= 1'b0;
			any_q       <= 1'b0;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			tail_q      <= 1'b0;
			idx_q       <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				count_q <= n_count;
				dseen_q <= n_dseen;
				any_q   <= n_any;
				fill_q  <= n_fill;
				ovf_q   <= n_ovf;
				tail_q  <= res_v;
				len_q   <= fill_q;
				idx_q   <= '0;
			end else if (cmd.load_flush) begin
				idx_q <= idx_q + FW'(1);
			end
			if (load_imm || cmd.load_flush || cmd.load_tail) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tail_byte_q <= res_b;
			trunc_q     <= res_t;
		end
		if (load_imm) begin
			out_byte_q  <= res_b;
			run_last_q  <= 1'b1;
			truncated_q <= res_t;
		end else if (cmd.load_flush) begin
			out_byte_q  <= rd_data_q;
			run_last_q  <= sts.flush_last && !tail_q;
			truncated_q <= trunc_q;
		end else if (cmd.load_tail) begin
			out_byte_q  <= tail_byte_q;
			run_last_q  <= 1'b1;
			truncated_q <= trunc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign truncated = truncated_q;

endmodule

@@ hdl/lcfs_checker.sv @@
module lcfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       truncated
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(run_last) && $stable(truncated))
		else $error("result beat changed while stalled");

	// A newline only ever closes the results of a byte.
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte == lcfs_pkg::NL_BYTE |-> run_last)
		else $error("newline result not marked last");

	// No new byte is taken while the output is blocked.
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// While a byte still owes results, no new byte is taken.
	a_run_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !in_ready)
		else $error("input taken in the middle of a result run");

endmodule

bind line_column_field_selector lcfs_checker u_lcfs_checker (.*);

@@ tb/line_column_field_selector_tb.sv @@
module line_column_field_selector_tb;

	localparam int unsigned MASK_POSITIONS = lcfs_pkg::MASK_POSITIONS_DEF;
	localparam int unsigned BUFFER_BYTES   = lcfs_pkg::BUFFER_BYTES_DEF;

	// A flush of a full first-field buffer plus its closing byte is the most
	// that one input byte can release.
	localparam int MAX_BEATS_PER_BYTE = BUFFER_BYTES + 1;

	// Quiet time before a register write, so that a flush still running
	// inside the block after the last awaited beat has surely finished.
	localparam int SETTLE_CYCLES = BUFFER_BYTES + 8;

	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASES           = 12;
	localparam int PHASE_BYTES      = 12;
	localparam int LIMIT_CYCLES     = 3000000;

	// Marks a byte whose results come from the line model rather than from
	// the stimulus table.
	localparam int BY_MODEL = -1;

	// No register sits at this index, so a write to it must change nothing.
	localparam logic [lcfs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam logic [7:0]                     COMMA_BYTE = 8'h2C;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       truncated;
	} out_beat_t;

	typedef enum logic {
		ROW_CFG,
		ROW_BYTE
	} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [lcfs_pkg::CFG_IDX_W-1:0]  index;
		logic [lcfs_pkg::CFG_DATA_W-1:0] data;
		logic [7:0]                      value;
		int                              beats;
	} stim_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [7:0]                      in_byte;
	logic                            out_valid;
	logic                            out_ready;
	logic [7:0]                      out_byte;
	logic                            run_last;
	logic                            truncated;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [lcfs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lcfs_pkg::CFG_DATA_W-1:0] cfg_data;

	// Travels with each input beat: either BY_MODEL or the number of result
	// beats (none or one, echoing the byte) that the table row states.
	int offer_beats;

	// Selection settings as the block should hold them.
	logic        sel_mode;
	logic [63:0] sel_mask;
	logic [6:0]  sel_max_pos;
	logic        sel_open;
	logic [7:0]  sel_delim;
	logic        sel_suppress;

	// Line state of the model.
	int         pos_count;
	logic       delim_seen;
	logic       field_started;
	logic [7:0] field1_buf [BUFFER_BYTES];
	int         field1_fill;
	logic       field1_overflow;

	out_beat_t step_beats[$];
	out_beat_t expected_out[$];
	stim_row_t stim_rows[$];

	int  error_count   = 0;
	int  beats_checked = 0;
	int  trunc_beats   = 0;
	int  items_sent    = 0;
	int  writes_done   = 0;
	bit  quiet         = 1'b0;
	bit  hold_request  = 1'b0;

	line_column_field_selector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.truncated (truncated),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Line model
	// ------------------------------------------------------------------

	// Position k counts from one. Positions past the listed range, or a
	// listed range of zero, fall to the open tail; a range wider than the
	// mask is clipped to the mask.
	function automatic bit position_picked(input int k);
		int m;
		m = (sel_max_pos > MASK_POSITIONS) ? MASK_POSITIONS : sel_max_pos;
		if (k > m || k == 0)
			return sel_open;
		return sel_mask[k-1];
	endfunction

	function automatic int next_position(input int c);
		return (c < 127) ? c + 1 : 127;
	endfunction

	function automatic void emit(input logic [7:0] b, input logic trunc);
		out_beat_t r;
		if (step_beats.size() < MAX_BEATS_PER_BYTE) begin
			r.out_byte  = b;
			r.run_last  = 1'b0;
			r.truncated = trunc;
			step_beats.push_back(r);
		end
	endfunction

	function automatic void clear_line();
		pos_count       = 0;
		delim_seen      = 1'b0;
		field_started   = 1'b0;
		field1_fill     = 0;
		field1_overflow = 1'b0;
	endfunction

	// Works out every result beat that one input byte releases and leaves
	// them in step_beats, the final one marked as the end of the run.
	function automatic void select_step(input logic [7:0] b);
		out_beat_t tail_beat;
		logic      trunc;
		step_beats.delete();
		if (!sel_mode) begin
			if (b == lcfs_pkg::NL_BYTE) begin
				emit(lcfs_pkg::NL_BYTE, 1'b0);
				clear_line();
			end else begin
				pos_count = next_position(pos_count);
				if (position_picked(pos_count))
					emit(b, 1'b0);
			end
		end else if (b == lcfs_pkg::NL_BYTE) begin
			// The overflow mark of the line goes out on its newline as well.
			trunc = field1_overflow;
			if (delim_seen) begin
				emit(lcfs_pkg::NL_BYTE, trunc);
			end else if (!sel_suppress) begin
				for (int i = 0; i < field1_fill; i++)
					emit(field1_buf[i], trunc);
				emit(lcfs_pkg::NL_BYTE, trunc);
			end
			clear_line();
		end else if (!delim_seen) begin
			if (b == sel_delim) begin
				// First delimiter: field 1 is released if it is wanted.
				delim_seen = 1'b1;
				if (position_picked(1)) begin
					for (int i = 0; i < field1_fill; i++)
						emit(field1_buf[i], field1_overflow);
					field_started = 1'b1;
				end
				field1_fill = 0;
				pos_count   = 1;
				if (position_picked(2)) begin
					if (field_started)
						emit(sel_delim, field1_overflow);
					field_started = 1'b1;
				end
			end else if (field1_fill < BUFFER_BYTES) begin
				field1_buf[field1_fill] = b;
				field1_fill++;
			end else begin
				field1_overflow = 1'b1;
			end
		end else if (b == sel_delim) begin
			pos_count = next_position(pos_count);
			if (position_picked(pos_count + 1)) begin
				if (field_started)
					emit(sel_delim, field1_overflow);
				field_started = 1'b1;
			end
		end else if (position_picked(pos_count + 1)) begin
			emit(b, field1_overflow);
		end
		if (step_beats.size() != 0) begin
			tail_beat = step_beats.pop_back();
			tail_beat.run_last = 1'b1;
			step_beats.push_back(tail_beat);
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: follows register writes, predicts on every accepted input
	// beat and compares every accepted output beat with the oldest one
	// still awaited. All handshakes are sampled at the rising edge, before
	// any nonblocking update of that edge lands.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		out_beat_t want;
		if (!arst_n) begin
			sel_mode     = 1'b0;
			sel_mask     = '0;
			sel_max_pos  = lcfs_pkg::MAX_POS_RST;
			sel_open     = 1'b0;
			sel_delim    = lcfs_pkg::TAB_BYTE;
			sel_suppress = 1'b0;
			clear_line();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lcfs_pkg::CFG_MODE:     sel_mode     = cfg_data[0];
					lcfs_pkg::CFG_MASK:     sel_mask     = cfg_data;
					lcfs_pkg::CFG_MAX_POS:  sel_max_pos  = cfg_data[6:0];
					lcfs_pkg::CFG_OPEN:     sel_open     = cfg_data[0];
					lcfs_pkg::CFG_DELIM:    sel_delim    = cfg_data[7:0];
					lcfs_pkg::CFG_SUPPRESS: sel_suppress = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				// The model always runs so that its line state moves on;
				// a table row with a stated outcome replaces its results.
				select_step(in_byte);
				if (offer_beats != BY_MODEL) begin
					step_beats.delete();
					if (offer_beats == 1) begin
						want.out_byte  = in_byte;
						want.run_last  = 1'b1;
						want.truncated = 1'b0;
						step_beats.push_back(want);
					end
				end
				foreach (step_beats[i])
					expected_out.push_back(step_beats[i]);
			end
			if (out_valid && out_ready) begin
				if (expected_out.size() == 0) begin
					$error("out_byte: no beat expected, actual %0d", out_byte);
					error_count++;
				end else begin
					want = expected_out.pop_front();
					if (out_byte !== want.out_byte) begin
						$error("out_byte: expected %0d, actual %0d", want.out_byte, out_byte);
						error_count++;
					end
					if (run_last !== want.run_last) begin
						$error("run_last: expected %0d, actual %0d", want.run_last, run_last);
						error_count++;
					end
					if (truncated !== want.truncated) begin
						$error("truncated: expected %0d, actual %0d", want.truncated,
							truncated);
						error_count++;
					end
					beats_checked++;
					if (want.truncated)
						trunc_beats++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: mostly ready, with random stalls, one long hold-off on
	// request so that the block backs up into its input, and no stalls at
	// all once the run has gone quiet.
	// ------------------------------------------------------------------
	initial begin : receiver
		bit hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offers one byte and returns at the edge where it is taken. Valid is
	// only lowered when a gap is to follow, so back-to-back beats keep it
	// high without a second assignment in the same step.
	task automatic offer_byte(input logic [7:0] b, input int beats = BY_MODEL);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_byte     <= b;
		offer_beats <= beats;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Lets the block run dry: every awaited beat out, then a quiet spell in
	// case a byte with no result left a flush running.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lcfs_pkg::CFG_IDX_W-1:0] idx,
		input logic [lcfs_pkg::CFG_DATA_W-1:0] data);
		settle();
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		writes_done++;
	endtask

	// Text byte for a line: mostly anything but the newline and the
	// delimiter, now and then any byte at all to break the line shape.
	function automatic logic [7:0] line_byte(input logic [7:0] delim);
		logic [7:0] b;
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		do
			b = 8'($urandom_range(0, 255));
		while (b == lcfs_pkg::NL_BYTE || b == delim);
		return b;
	endfunction

	// A delimited line of short fields; some lines have no delimiter, and
	// some open with a field 1 long enough to overrun the buffer.
	task automatic send_field_line(input logic [7:0] delim);
		int fields;
		int len;
		fields = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 6);
		for (int f = 0; f < fields; f++) begin
			if (f == 0 && $urandom_range(0, 5) == 0)
				len = $urandom_range(BUFFER_BYTES - 2, BUFFER_BYTES + 8);
			else
				len = $urandom_range(0, 4);
			repeat (len) offer_byte(line_byte(delim));
			if (f != fields - 1)
				offer_byte(delim);
		end
		offer_byte(lcfs_pkg::NL_BYTE);
	endtask

	// A line of columns; now and then one long enough to saturate the
	// column count.
	task automatic send_byte_line();
		int len;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(128, 136) : $urandom_range(0, 24);
		repeat (len) offer_byte(line_byte(lcfs_pkg::NL_BYTE));
		offer_byte(lcfs_pkg::NL_BYTE);
	endtask

	function automatic void cfg_row(input logic [lcfs_pkg::CFG_IDX_W-1:0] idx,
		input logic [lcfs_pkg::CFG_DATA_W-1:0] data);
		stim_row_t r;
		r.kind  = ROW_CFG;
		r.index = idx;
		r.data  = data;
		r.value = 8'h00;
		r.beats = BY_MODEL;
		stim_rows.push_back(r);
	endfunction

	function automatic void byte_row(input logic [7:0] b, input int beats = BY_MODEL);
		stim_row_t r;
		r.kind  = ROW_BYTE;
		r.index = lcfs_pkg::CFG_MODE;
		r.data  = '0;
		r.value = b;
		r.beats = beats;
		stim_rows.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic        mode;
		logic [63:0] mask;
		logic [6:0]  max_pos;
		logic [7:0]  delim;
		int          start;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_byte     = 8'h00;
		offer_beats = BY_MODEL;
		cfg_valid   = 1'b0;
		cfg_index   = lcfs_pkg::CFG_MODE;
		cfg_data    = '0;

		// Out of reset nothing is selected: columns give nothing, the
		// newline always goes through.
		byte_row(8'h41, 0);
		byte_row(lcfs_pkg::NL_BYTE, 1);
		// Every column listed, at the widest range.
		cfg_row(lcfs_pkg::CFG_MASK, '1);
		cfg_row(lcfs_pkg::CFG_MAX_POS, 64'd64);
		byte_row(8'h00, 1);
		byte_row(8'hFF, 1);
		byte_row(lcfs_pkg::NL_BYTE, 1);
		// A listed range of zero puts every column in the open tail.
		cfg_row(lcfs_pkg::CFG_MAX_POS, 64'd0);
		cfg_row(lcfs_pkg::CFG_OPEN, 64'd1);
		byte_row(8'h78, 1);
		byte_row(lcfs_pkg::NL_BYTE, 1);
		// A range above the mask width is clipped; only column 1 of the
		// first two is wanted.
		cfg_row(lcfs_pkg::CFG_MAX_POS, 64'd127);
		cfg_row(lcfs_pkg::CFG_OPEN, 64'd0);
		cfg_row(lcfs_pkg::CFG_MASK, 64'h8000_0000_0000_0001);
		byte_row(8'h61, 1);
		byte_row(8'h62, 0);
		byte_row(lcfs_pkg::NL_BYTE, 1);
		// Field mode on tabs: fields 1 and 3 listed, open tail beyond 3.
		// A write to an index with no register behind it goes in last.
		cfg_row(lcfs_pkg::CFG_MODE, 64'd1);
		cfg_row(lcfs_pkg::CFG_MASK, 64'h5);
		cfg_row(lcfs_pkg::CFG_MAX_POS, 64'd3);
		cfg_row(lcfs_pkg::CFG_OPEN, 64'd1);
		cfg_row(CFG_UNUSED, '1);
		byte_row(8'h61);
		byte_row(8'h62);
		byte_row(lcfs_pkg::TAB_BYTE);
		byte_row(8'h63);
		byte_row(lcfs_pkg::TAB_BYTE);
		byte_row(8'h64);
		byte_row(lcfs_pkg::TAB_BYTE);
		byte_row(8'h65);
		byte_row(lcfs_pkg::NL_BYTE);
		// A line without any delimiter is echoed whole...
		byte_row(8'h71);
		byte_row(lcfs_pkg::NL_BYTE);
		// ...or dropped, newline and all, when suppression is on.
		cfg_row(lcfs_pkg::CFG_SUPPRESS, 64'd1);
		byte_row(8'h72);
		byte_row(lcfs_pkg::NL_BYTE, 0);
		// A newline delimiter never splits anything, so the line counts as
		// undelimited and is dropped as well.
		cfg_row(lcfs_pkg::CFG_DELIM, 64'(lcfs_pkg::NL_BYTE));
		byte_row(8'h73);
		byte_row(lcfs_pkg::NL_BYTE, 0);
		// A change of selection in the middle of a line takes hold at once.
		cfg_row(lcfs_pkg::CFG_DELIM, 64'(COMMA_BYTE));
		cfg_row(lcfs_pkg::CFG_SUPPRESS, 64'd0);
		byte_row(8'h75);
		byte_row(COMMA_BYTE);
		cfg_row(lcfs_pkg::CFG_MASK, 64'h2);
		byte_row(8'h77);
		byte_row(lcfs_pkg::NL_BYTE);
		// A field 1 longer than the buffer loses its excess and marks the
		// rest of its line as truncated; an undelimited one of the same
		// kind then gives the longest run of results a byte can release.
		cfg_row(lcfs_pkg::CFG_MASK, 64'h1);
		repeat (BUFFER_BYTES + 2) byte_row(8'h7A);
		byte_row(COMMA_BYTE);
		byte_row(8'h7B);
		byte_row(lcfs_pkg::NL_BYTE);
		repeat (BUFFER_BYTES + 3) byte_row(8'h7C);
		byte_row(lcfs_pkg::NL_BYTE);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[r]) begin
			if (stim_rows[r].kind == ROW_CFG)
				write_reg(stim_rows[r].index, stim_rows[r].data);
			else
				offer_byte(stim_rows[r].value, stim_rows[r].beats);
		end

		// Random phases, each with a fresh set of registers. Field mode
		// gets two phases in three since it holds most of the behaviour.
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 2)
				quiet = 1'b1;
			mode    = (p % 3 != 0);
			mask    = {$urandom, $urandom};
			max_pos = mode ? 7'($urandom_range(0, 8)) : 7'($urandom_range(0, 24));
			case ($urandom_range(0, 11))
				0, 1, 2: delim = lcfs_pkg::TAB_BYTE;
				3, 4:    delim = COMMA_BYTE;
				5:       delim = 8'h00;
				6:       delim = 8'hFF;
				7:       delim = lcfs_pkg::NL_BYTE;
				default: delim = 8'($urandom_range(0, 255));
			endcase
			case (p)
				1: begin
					mask    = '1;
					max_pos = 7'd64;
					delim   = 8'h00;
				end
				2: begin
					mask    = '0;
					max_pos = 7'd0;
					delim   = 8'hFF;
				end
				4: max_pos = 7'd127;
				default: ;
			endcase
			write_reg(lcfs_pkg::CFG_MODE, 64'(mode));
			write_reg(lcfs_pkg::CFG_MASK, mask);
			write_reg(lcfs_pkg::CFG_MAX_POS, 64'(max_pos));
			write_reg(lcfs_pkg::CFG_OPEN,
				(p == 1) ? 64'd1 : (p == 2) ? 64'd0 : 64'($urandom_range(0, 1)));
			write_reg(lcfs_pkg::CFG_DELIM, 64'(delim));
			write_reg(lcfs_pkg::CFG_SUPPRESS, 64'($urandom_range(0, 1)));
			// One byte-mode phase opens with a long hold-off on the output
			// while bytes keep coming, so the block has to stall its input.
			if (p == 3)
				hold_request = 1'b1;
			start = items_sent;
			while (items_sent - start < PHASE_BYTES) begin
				if (mode)
					send_field_line(delim);
				else
					send_byte_line();
			end
		end

		settle();
		$display("Sent %0d bytes and %0d register writes; checked %0d result beats, %0d truncated.",
			items_sent, writes_done, beats_checked, trunc_beats);
		$display("Both modes, extreme selections, buffer overrun, suppression and a long stall ran.");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Hard stop well past the slowest run that can still be correct.
	initial begin : watchdog
		#(LIMIT_CYCLES * 10);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
